FILE: rtl/atanbr_pkg.sv
// ----------------------------------------------------------------------------
// atanbr_pkg
// Shared types, constants and the arctangent table of the angle block.
// ----------------------------------------------------------------------------
`default_nettype none

package atanbr_pkg;

  localparam int unsigned CoordW     = 32;
  localparam int unsigned AngleW     = 17;
  localparam int unsigned FoldW      = CoordW + 2;
  // One octant of ratio, 2^RatioShift.
  localparam int unsigned RatioShift = 14;
  localparam int unsigned QuotW      = RatioShift + 1;
  localparam int unsigned LutW       = 16;
  localparam int unsigned LutLast    = 128;
  localparam int unsigned LutIdxW    = 8;
  localparam int unsigned TableStepDefault = 128;

  // Numerators at or above this no longer fit 32 bits after the octant scale.
  localparam logic [CoordW-1:0] PrescaleLimit = 32'h0004_0000;
  localparam logic signed [CoordW-1:0] CoordMin = 32'sh8000_0000;
  localparam logic signed [CoordW-1:0] CoordSat = 32'sh8000_0001;

  localparam logic signed [AngleW-1:0] AngleHalfNeg = -17'sd32768;
  localparam logic signed [AngleW-1:0] AngleQuarter = 17'sd16384;
  localparam logic signed [AngleW-1:0] AngleEighth  = 17'sd8192;

  typedef struct packed {
    logic                      zero;
    logic signed [AngleW-1:0]  base;
  } atanbr_side_t;

  localparam logic [LutW-1:0] AtanLut [LutLast+1] = '{
    16'h0000, 16'h0051, 16'h00a2, 16'h00f4, 16'h0145, 16'h0197, 16'h01e8, 16'h0239,
    16'h028b, 16'h02dc, 16'h032d, 16'h037e, 16'h03ce, 16'h041f, 16'h0470, 16'h04c0,
    16'h0511, 16'h0561, 16'h05b1, 16'h0601, 16'h0650, 16'h06a0, 16'h06ef, 16'h073e,
    16'h078d, 16'h07db, 16'h082a, 16'h0878, 16'h08c6, 16'h0913, 16'h0961, 16'h09ae,
    16'h09fb, 16'h0a47, 16'h0a94, 16'h0ae0, 16'h0b2b, 16'h0b77, 16'h0bc2, 16'h0c0c,
    16'h0c57, 16'h0ca1, 16'h0ceb, 16'h0d34, 16'h0d7d, 16'h0dc6, 16'h0e0e, 16'h0e56,
    16'h0e9e, 16'h0ee5, 16'h0f2c, 16'h0f72, 16'h0fb8, 16'h0ffe, 16'h1044, 16'h1089,
    16'h10cd, 16'h1111, 16'h1155, 16'h1199, 16'h11dc, 16'h121e, 16'h1260, 16'h12a2,
    16'h12e4, 16'h1325, 16'h1365, 16'h13a5, 16'h13e5, 16'h1424, 16'h1463, 16'h14a2,
    16'h14e0, 16'h151e, 16'h155b, 16'h1598, 16'h15d4, 16'h1610, 16'h164c, 16'h1687,
    16'h16c2, 16'h16fc, 16'h1736, 16'h1770, 16'h17a9, 16'h17e2, 16'h181a, 16'h1852,
    16'h188a, 16'h18c1, 16'h18f7, 16'h192e, 16'h1964, 16'h1999, 16'h19ce, 16'h1a03,
    16'h1a37, 16'h1a6b, 16'h1a9f, 16'h1ad2, 16'h1b05, 16'h1b37, 16'h1b69, 16'h1b9b,
    16'h1bcc, 16'h1bfd, 16'h1c2e, 16'h1c5e, 16'h1c8e, 16'h1cbd, 16'h1cec, 16'h1d1b,
    16'h1d49, 16'h1d77, 16'h1da5, 16'h1dd2, 16'h1dff, 16'h1e2c, 16'h1e58, 16'h1e84,
    16'h1eaf, 16'h1eda, 16'h1f05, 16'h1f30, 16'h1f5a, 16'h1f84, 16'h1fad, 16'h1fd7,
    16'h2000
  };

endpackage

`default_nettype wire

FILE: rtl/atanbr_if.sv
// ----------------------------------------------------------------------------
// atanbr_in_if / atanbr_out_if
// Valid/ready channels for the coordinate beat and the angle beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface atanbr_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coord_y;
  logic signed [31:0] coord_x;

  modport source (output valid, output coord_y, output coord_x, input ready);
  modport sink   (input valid, input coord_y, input coord_x, output ready);
endinterface

interface atanbr_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

`default_nettype wire

FILE: rtl/atanbr_div.sv
// ----------------------------------------------------------------------------
// atanbr_div
// Pipelined restoring divider, one quotient bit per stage, with side data.
// ----------------------------------------------------------------------------
`default_nettype none

module atanbr_div
  import atanbr_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire logic [CoordW-1:0]    num_i,
  input  wire logic [CoordW-1:0]    den_i,
  input  wire atanbr_side_t         side_i,
  output logic                      valid_o,
  output logic [QuotW-1:0]          quot_o,
  output atanbr_side_t              side_o
);

  logic                 vld_w  [QuotW+1];
  logic [CoordW-1:0]    rem_w  [QuotW+1];
  logic [CoordW-1:0]    num_w  [QuotW+1];
  logic [CoordW-1:0]    den_w  [QuotW+1];
  logic [QuotW-1:0]     quot_w [QuotW+1];
  atanbr_side_t         side_w [QuotW+1];

  // The quotient stays below 2^QuotW, so the top bits start as the remainder.
  assign vld_w[0]  = valid_i;
  assign rem_w[0]  = CoordW'(num_i >> QuotW);
  assign num_w[0]  = num_i;
  assign den_w[0]  = den_i;
  assign quot_w[0] = '0;
  assign side_w[0] = side_i;

  for (genvar k = 0; k < QuotW; k++) begin : g_step
    logic [CoordW:0]      trial;
    logic                 ge;
    logic [CoordW:0]      diff;
    logic [QuotW-1:0]     quot_d;
    logic                 vld_q;
    logic [CoordW-1:0]    rem_q;
    logic [CoordW-1:0]    num_q;
    logic [CoordW-1:0]    den_q;
    logic [QuotW-1:0]     quot_q;
    atanbr_side_t         side_q;

    always_comb begin
      trial  = {rem_w[k], num_w[k][QuotW-1-k]};
      ge     = trial >= {1'b0, den_w[k]};
      diff   = trial - {1'b0, den_w[k]};
      quot_d = quot_w[k];
      quot_d[QuotW-1-k] = ge;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_w[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q  <= ge ? diff[CoordW-1:0] : trial[CoordW-1:0];
        num_q  <= num_w[k];
        den_q  <= den_w[k];
        quot_q <= quot_d;
        side_q <= side_w[k];
      end
    end

    assign vld_w[k+1]  = vld_q;
    assign rem_w[k+1]  = rem_q;
    assign num_w[k+1]  = num_q;
    assign den_w[k+1]  = den_q;
    assign quot_w[k+1] = quot_q;
    assign side_w[k+1] = side_q;
  end

  assign valid_o = vld_w[QuotW];
  assign quot_o  = quot_w[QuotW];
  assign side_o  = side_w[QuotW];

  // The remainder of the last step stays below the divisor.
  a_rem_below_den : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_w[QuotW] && !side_w[QuotW].zero |-> rem_w[QuotW] < den_w[QuotW])
    else $error("divider remainder not below divisor");

  // The ratio of a folded point never exceeds one octant.
  a_quot_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !side_o.zero |-> quot_o <= QuotW'(1 << RatioShift))
    else $error("ratio beyond one octant");

  // A stalled pipeline keeps its last stage.
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(valid_o) && $stable(quot_o))
    else $error("divider output moved during stall");

endmodule

`default_nettype wire

FILE: rtl/atan2_binary_radians.sv
// ----------------------------------------------------------------------------
// atan2_binary_radians
// Angle of a signed point in binary radians, 65536 per full turn.
// ----------------------------------------------------------------------------
// The block takes a beat of (coord_y, coord_x) and returns one beat holding
// the angle of that point, where +32768 is half a turn; the origin gives 0 and
// a coordinate of -2^31 is treated as -2^31+1. It accepts a new beat in every
// cycle while the output is not held back, and each beat passes through 21
// register stages: three stages fold the point into the first octant and
// scale it, fifteen stages of the restoring divider form one ratio bit each,
// and three stages look up, weigh and sum the table interpolation. The whole
// pipeline advances together and holds while a finished angle waits for the
// output ready, so the beats in flight wait with it and no beat is lost or
// repeated. TableStep must be a power of two between 16 and 1024; the
// arctangent table is laid out for 128.
// ----------------------------------------------------------------------------
`default_nettype none

module atan2_binary_radians
  import atanbr_pkg::*;
#(
  parameter int unsigned TableStep = TableStepDefault
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  atanbr_in_if.sink     in_i,
  atanbr_out_if.source  out_o
);

  localparam int unsigned StepW = $clog2(TableStep);
  localparam int unsigned ProdW = LutW + StepW;

  logic en;

  // Stage 1: saturate and turn the lower half plane by 180 degrees.
  logic signed [CoordW-1:0] ys, xs;
  logic signed [FoldW-1:0]  y1_d, x1_d, y1_q, x1_q;
  atanbr_side_t             s1_d, s1_q;
  logic                     v1_q;

  always_comb begin
    ys = (in_i.coord_y == CoordMin) ? CoordSat : in_i.coord_y;
    xs = (in_i.coord_x == CoordMin) ? CoordSat : in_i.coord_x;
    s1_d.zero = (in_i.coord_y == '0) && (in_i.coord_x == '0);
    if (ys < 0) begin
      y1_d = -FoldW'(ys);
      x1_d = -FoldW'(xs);
      s1_d.base = AngleHalfNeg;
    end else begin
      y1_d = FoldW'(ys);
      x1_d = FoldW'(xs);
      s1_d.base = '0;
    end
  end

  // Stage 2: turn by 90 degrees onto x >= 0, then by 45 degrees below the
  // diagonal.
  logic signed [FoldW-1:0]  ya, xa, yb, xb;
  atanbr_side_t             s2_d, s2_q;
  logic [CoordW-1:0]        num2_q, den2_q;
  logic                     v2_q;

  always_comb begin
    s2_d = s1_q;
    if (x1_q <= 0) begin
      xa = y1_q;
      ya = -x1_q;
      s2_d.base = s1_q.base + AngleQuarter;
    end else begin
      xa = x1_q;
      ya = y1_q;
    end
    if (xa < ya) begin
      xb = xa + ya;
      yb = ya - xa;
      s2_d.base = s2_d.base + AngleEighth;
    end else begin
      xb = xa;
      yb = ya;
    end
  end

  // Stage 3: scale both down when the numerator would overflow, and keep the divisor nonzero.
  logic [CoordW-1:0] nsc, dsc;
  logic [CoordW-1:0] num3_q, den3_q;
  atanbr_side_t      s3_q;
  logic              v3_q;

  always_comb begin
    if (num2_q >= PrescaleLimit) begin
      nsc = num2_q >> RatioShift;
      dsc = den2_q >> RatioShift;
    end else begin
      nsc = num2_q;
      dsc = den2_q;
    end
    if (dsc == '0) begin
      dsc = CoordW'(1);
    end
  end

  // Divider: ratio = num * 2^RatioShift / den.
  logic              vd;
  logic [QuotW-1:0]  ratio;
  atanbr_side_t      sd;

  atanbr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .num_i   (num3_q),
    .den_i   (den3_q),
    .side_i  (s3_q),
    .valid_o (vd),
    .quot_o  (ratio),
    .side_o  (sd)
  );

  // Stage L: table lookup; both ends clamp at the last entry.
  logic [QuotW-1:0]   idx_full, nxt_full;
  logic [LutIdxW-1:0] idx, nxt;
  logic [LutW-1:0]    lo_d, lo_q, diff_q;
  logic [StepW-1:0]   wgt_q;
  atanbr_side_t       sl_q;
  logic               vl_q;

  always_comb begin
    idx_full = ratio >> StepW;
    nxt_full = idx_full + QuotW'(1);
    idx = (idx_full > QuotW'(LutLast)) ? LutIdxW'(LutLast) : idx_full[LutIdxW-1:0];
    nxt = (nxt_full > QuotW'(LutLast)) ? LutIdxW'(LutLast) : nxt_full[LutIdxW-1:0];
    lo_d = AtanLut[idx];
  end

  // Stage M: weight the step between neighbors.
  logic [ProdW-1:0]  prod_q;
  logic [LutW-1:0]   lom_q;
  atanbr_side_t      sm_q;
  logic              vm_q;

  // Output stage.
  logic                     vo_q;
  logic signed [AngleW-1:0] angle_q;
  logic signed [AngleW-1:0] angle_d;

  always_comb begin
    angle_d = sm_q.base + AngleW'(lom_q) + AngleW'(prod_q >> StepW);
    if (sm_q.zero) begin
      angle_d = '0;
    end
  end

  assign en          = !vo_q || out_o.ready;
  assign in_i.ready  = en;
  assign out_o.valid = vo_q;
  assign out_o.angle = angle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vl_q <= 1'b0;
      vm_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vl_q <= vd;
      vm_q <= vl_q;
      vo_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      y1_q    <= y1_d;
      x1_q    <= x1_d;
      s1_q    <= s1_d;
      num2_q  <= yb[CoordW-1:0];
      den2_q  <= xb[CoordW-1:0];
      s2_q    <= s2_d;
      num3_q  <= nsc << RatioShift;
      den3_q  <= dsc;
      s3_q    <= s2_q;
      lo_q    <= lo_d;
      diff_q  <= AtanLut[nxt] - lo_d;
      wgt_q   <= ratio[StepW-1:0];
      sl_q    <= sd;
      prod_q  <= ProdW'(diff_q) * ProdW'(wgt_q);
      lom_q   <= lo_q;
      sm_q    <= sl_q;
      angle_q <= angle_d;
    end
  end

  // A folded point lies in the first octant.
  a_octant : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q && !s2_q.zero |-> num2_q <= den2_q && den2_q != '0)
    else $error("fold left the first octant");

  // Every angle lies within half a turn either way.
  a_angle_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vo_q |-> angle_q >= AngleHalfNeg && angle_q <= -AngleHalfNeg)
    else $error("angle out of range");

  // The origin travels to a zero angle.
  a_origin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && vm_q && sm_q.zero |=> angle_q == '0)
    else $error("origin gave nonzero angle");

endmodule

`default_nettype wire
